FILE: rtl/bpt_pkg.sv
// Package for the buzzer pattern timer: command and result item types,
// command codes, state record and the key tone constants. No dependencies.
package bpt_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned TICK_W = 16;

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAUSE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESUME = 3'd4;
    localparam logic [KIND_W-1:0] KIND_KEY    = 3'd5;

    localparam logic [TICK_W-1:0] KEY_ON_TICKS  = 16'd5;
    localparam logic [TICK_W-1:0] KEY_OFF_TICKS = 16'd1;
    localparam logic [TICK_W-1:0] KEY_REPEATS   = 16'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TICK_W-1:0] on_ticks;
        logic [TICK_W-1:0] off_ticks;
        logic [TICK_W-1:0] repeat_count;
    } t_cmd;

    typedef struct packed {
        logic buzzer_on;
        logic active;
        logic muted;
    } t_res;

    typedef struct packed {
        logic              drive;
        logic              enabled;
        logic              mute_flag;
        logic              silent_phase;
        logic [TICK_W-1:0] on_len;
        logic [TICK_W-1:0] off_len;
        logic [TICK_W-1:0] cycle_limit;
        logic [TICK_W-1:0] cycles_done;
        logic [TICK_W-1:0] tick_count;
    } t_state;

    localparam t_state STATE_RESET = '0;

endpackage

FILE: rtl/bpt_cmd_if.sv
// Command channel of the buzzer pattern timer: valid, ready and one command item.
// Depends on bpt_pkg.
interface bpt_cmd_if;
    logic          valid;
    logic          ready;
    bpt_pkg::t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bpt_res_if.sv
// Result channel of the buzzer pattern timer: valid, ready and one result item.
// Depends on bpt_pkg.
interface bpt_res_if;
    logic          valid;
    logic          ready;
    bpt_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bpt_in_stage.sv
// Input register of the buzzer pattern timer: holds one command item until
// the core takes it. Depends on bpt_pkg.
module bpt_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bpt_pkg::t_cmd i_cmd,
    input  logic          i_take,
    output logic          o_valid,
    output bpt_pkg::t_cmd o_cmd
);

    logic          r_valid;
    logic          n_valid;
    bpt_pkg::t_cmd r_cmd;

    // The register may refill in the same cycle that its item is taken.
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

FILE: rtl/bpt_core.sv
// Pattern state and its update for one command item.
// Depends on bpt_pkg.
module bpt_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  bpt_pkg::t_cmd i_cmd,
    output bpt_pkg::t_res o_res
);

    bpt_pkg::t_state r_state;
    bpt_pkg::t_state n_state;

    always_comb begin
        logic [bpt_pkg::TICK_W-1:0] tc_inc;
        logic [bpt_pkg::TICK_W-1:0] cd_inc;
        logic [bpt_pkg::TICK_W-1:0] st_on;
        logic [bpt_pkg::TICK_W-1:0] st_off;
        logic [bpt_pkg::TICK_W-1:0] st_reps;
        logic                       is_start;
        logic                       is_stop;

        n_state  = r_state;
        tc_inc   = r_state.tick_count + 1'b1;
        cd_inc   = r_state.cycles_done + 1'b1;
        is_start = (i_cmd.kind == bpt_pkg::KIND_START) || (i_cmd.kind == bpt_pkg::KIND_KEY);
        is_stop  = (i_cmd.kind == bpt_pkg::KIND_STOP) || (i_cmd.kind == bpt_pkg::KIND_PAUSE)
                || (i_cmd.kind == bpt_pkg::KIND_RESUME);

        if (i_cmd.kind == bpt_pkg::KIND_KEY) begin
            st_on   = bpt_pkg::KEY_ON_TICKS;
            st_off  = bpt_pkg::KEY_OFF_TICKS;
            st_reps = bpt_pkg::KEY_REPEATS;
        end else begin
            st_on   = i_cmd.on_ticks;
            st_off  = i_cmd.off_ticks;
            st_reps = i_cmd.repeat_count;
        end

        if (i_cmd.kind == bpt_pkg::KIND_TICK) begin
            // Ticks only move an enabled, unmuted, non-continuous pattern.
            if (r_state.enabled && (r_state.off_len != '0) && !r_state.mute_flag) begin
                n_state.tick_count = tc_inc;
                if (!r_state.silent_phase) begin
                    if (tc_inc >= r_state.on_len) begin
                        n_state.drive        = 1'b0;
                        n_state.tick_count   = '0;
                        n_state.silent_phase = 1'b1;
                    end
                end else if (tc_inc >= r_state.off_len) begin
                    if ((r_state.cycle_limit != '0) && (cd_inc >= r_state.cycle_limit)) begin
                        // Final cycle ends: the pattern stops silent.
                        n_state.cycles_done = cd_inc;
                        n_state.enabled     = 1'b0;
                        n_state.off_len     = '0;
                    end else begin
                        if (r_state.cycle_limit != '0) begin
                            n_state.cycles_done = cd_inc;
                        end
                        n_state.tick_count   = '0;
                        n_state.silent_phase = 1'b0;
                        n_state.drive        = 1'b1;
                    end
                end
            end
        end else if (is_start) begin
            if ((st_on != '0) && !r_state.mute_flag) begin
                n_state.on_len       = st_on;
                n_state.off_len      = st_off;
                n_state.cycle_limit  = st_reps;
                n_state.cycles_done  = '0;
                n_state.tick_count   = '0;
                n_state.silent_phase = 1'b0;
                n_state.enabled      = 1'b1;
                n_state.drive        = 1'b1;
            end
        end else if (is_stop) begin
            // A stop keeps the buzzer level of a finite pattern with a silent phase.
            n_state.enabled = 1'b0;
            if ((r_state.off_len == '0) || (r_state.cycle_limit == '0)) begin
                n_state.drive = 1'b0;
            end
            if (i_cmd.kind == bpt_pkg::KIND_PAUSE) begin
                n_state.mute_flag = 1'b1;
            end else if (i_cmd.kind == bpt_pkg::KIND_RESUME) begin
                n_state.mute_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpt_pkg::STATE_RESET;
        end else if (i_go) begin
            r_state <= n_state;
        end
    end

    assign o_res.buzzer_on = n_state.drive;
    assign o_res.active    = n_state.enabled;
    assign o_res.muted     = n_state.mute_flag;

    a_muted_start_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && r_state.mute_flag && ((i_cmd.kind == bpt_pkg::KIND_START)
            || (i_cmd.kind == bpt_pkg::KIND_KEY))) |=> (r_state == $past(r_state)))
        else $error("start changed state while muted");

    a_stop_disables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && ((i_cmd.kind == bpt_pkg::KIND_STOP) || (i_cmd.kind == bpt_pkg::KIND_PAUSE)
            || (i_cmd.kind == bpt_pkg::KIND_RESUME))) |=> !r_state.enabled)
        else $error("pattern still enabled after a stop");

    a_silent_is_off: assert property (@(posedge i_clk)
        r_state.silent_phase |-> !r_state.drive)
        else $error("buzzer driven during the silent phase");

    a_enabled_has_on_time: assert property (@(posedge i_clk)
        r_state.enabled |-> (r_state.on_len != '0))
        else $error("pattern enabled with zero on time");

endmodule

FILE: rtl/bpt_out_stage.sv
// Output register of the buzzer pattern timer: holds one result item until
// the receiver takes it. Depends on bpt_pkg.
module bpt_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  bpt_pkg::t_res i_res,
    output logic          o_free,
    input  logic          i_ready,
    output logic          o_valid,
    output bpt_pkg::t_res o_res
);

    logic          r_valid;
    bpt_pkg::t_res r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: rtl/buzzer_pattern_timer_top.sv
// Top level of the buzzer pattern timer: input register, pattern core and
// output register. Depends on bpt_pkg, bpt_cmd_if, bpt_res_if and the bpt_ modules.
//
// Usage:
//   i_cmd carries one command item per handshake: tick, start, stop, pause,
//   resume or key tone, with on time, off time and repeat count for a start.
//   o_res returns exactly one item per command: buzzer level, pattern active
//   and mute flag as they stand after that command.
//   An accepted item waits in the input register until the output register is
//   free, is then processed by the core, and its result is registered in the
//   output register and offered on o_res. While o_res is not stalled, commands are
//   accepted every cycle and throughput is one item per cycle.
//   Reset (synchronous, active low) clears the pattern state, the mute flag
//   and both registers; no item is held afterwards.
//   When the receiver stalls, the result waits in the output register, one more
//   item waits in the input register, and then i_cmd.ready drops until o_res
//   is taken again. No item is lost or repeated.
module buzzer_pattern_timer_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bpt_cmd_if.sink        i_cmd,
    bpt_res_if.source      o_res
);

    logic          w_in_valid;
    bpt_pkg::t_cmd w_in_cmd;
    logic          w_out_free;
    logic          w_go;
    bpt_pkg::t_res w_res;

    assign w_go = w_in_valid && w_out_free;

    bpt_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (i_cmd.ready),
        .i_cmd   (i_cmd.data),
        .i_take  (w_go),
        .o_valid (w_in_valid),
        .o_cmd   (w_in_cmd)
    );

    bpt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_cmd   (w_in_cmd),
        .o_res   (w_res)
    );

    bpt_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_go),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_res   (o_res.data)
    );

endmodule

FILE: dv/bpt_pattern_checker.sv
// Checker for the buzzer pattern timer: watches the command and result channels,
// predicts buzzer level, active and mute after each command, and compares.
// Depends on bpt_pkg, bpt_cmd_if and bpt_res_if.
`timescale 1ns / 1ps

module bpt_pattern_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpt_cmd_if          i_cmd,
    bpt_res_if          i_res,
    output int unsigned o_mismatches,
    output int unsigned o_outstanding
);
    import bpt_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    t_state      pattern = STATE_RESET;
    t_res        expected_levels[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    function automatic t_state load_pattern(t_state s, logic [TICK_W-1:0] on_t,
                                            logic [TICK_W-1:0] off_t,
                                            logic [TICK_W-1:0] reps);
        if (on_t != '0 && !s.mute_flag) begin
            s.on_len       = on_t;
            s.off_len      = off_t;
            s.cycle_limit  = reps;
            s.cycles_done  = '0;
            s.tick_count   = '0;
            s.silent_phase = 1'b0;
            s.enabled      = 1'b1;
            s.drive        = 1'b1;
        end
        return s;
    endfunction

    // A stop keeps the current level unless the pattern is continuous or endless.
    function automatic t_state halt_pattern(t_state s);
        s.enabled = 1'b0;
        if (s.off_len == '0 || s.cycle_limit == '0) begin
            s.drive = 1'b0;
        end
        return s;
    endfunction

    function automatic t_state apply_command(t_state s, t_cmd c);
        logic finished;
        finished = 1'b0;
        case (c.kind)
            KIND_TICK: begin
                if (s.enabled && s.off_len != '0 && !s.mute_flag) begin
                    s.tick_count = s.tick_count + 1'b1;
                    if (!s.silent_phase) begin
                        if (s.tick_count >= s.on_len) begin
                            s.drive        = 1'b0;
                            s.tick_count   = '0;
                            s.silent_phase = 1'b1;
                        end
                    end else if (s.tick_count >= s.off_len) begin
                        if (s.cycle_limit != '0) begin
                            s.cycles_done = s.cycles_done + 1'b1;
                            finished      = (s.cycles_done >= s.cycle_limit);
                        end
                        // The final silent phase ends the pattern and leaves the buzzer off.
                        if (finished) begin
                            s.enabled = 1'b0;
                            s.off_len = '0;
                        end else begin
                            s.tick_count   = '0;
                            s.silent_phase = 1'b0;
                            s.drive        = 1'b1;
                        end
                    end
                end
            end
            KIND_START: begin
                s = load_pattern(s, c.on_ticks, c.off_ticks, c.repeat_count);
            end
            KIND_STOP: begin
                s = halt_pattern(s);
            end
            KIND_PAUSE: begin
                s = halt_pattern(s);
                s.mute_flag = 1'b1;
            end
            KIND_RESUME: begin
                s = halt_pattern(s);
                s.mute_flag = 1'b0;
            end
            KIND_KEY: begin
                s = load_pattern(s, KEY_ON_TICKS, KEY_OFF_TICKS, KEY_REPEATS);
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    task automatic note_mismatch(string field, logic want, logic got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("pattern check: result %0d %s expected %b got %b",
                     results_seen, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            pattern = STATE_RESET;
            expected_levels.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                pattern = apply_command(pattern, i_cmd.data);
                expected_levels.push_back(t_res'{pattern.drive, pattern.enabled,
                                                 pattern.mute_flag});
            end
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                results_seen++;
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("pattern check: result %0d arrived with none expected, got %b",
                                 results_seen, got);
                    end
                end else begin
                    want = expected_levels.pop_front();
                    if (got.buzzer_on !== want.buzzer_on) begin
                        note_mismatch("buzzer_on", want.buzzer_on, got.buzzer_on);
                    end
                    if (got.active !== want.active) begin
                        note_mismatch("active", want.active, got.active);
                    end
                    if (got.muted !== want.muted) begin
                        note_mismatch("muted", want.muted, got.muted);
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_levels.size();
    end

endmodule

FILE: dv/tb.sv
// Testbench top for the buzzer pattern timer: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict. Depends on bpt_pkg, the channel
// interfaces, buzzer_pattern_timer_top and bpt_pattern_checker.
`timescale 1ns / 1ps

module tb;
    import bpt_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1750;
    localparam int unsigned SEGMENT_ITEMS  = 220;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned issued = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches;
    int unsigned outstanding;

    bpt_cmd_if cmd_ch ();
    bpt_res_if res_ch ();

    buzzer_pattern_timer_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    bpt_pattern_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd         (cmd_ch),
        .i_res         (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        res_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Any accepted item on either side restarts the count.
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_cmd make_cmd(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] on_t,
                                      logic [TICK_W-1:0] off_t, logic [TICK_W-1:0] reps);
        t_cmd c;
        c.kind         = kind;
        c.on_ticks     = on_t;
        c.off_ticks    = off_t;
        c.repeat_count = reps;
        return c;
    endfunction

    // Mostly short lengths so that patterns run through many phases.
    function automatic logic [TICK_W-1:0] pick_len(int unsigned zero_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < zero_pct) begin
            return '0;
        end else if (r < 60) begin
            return TICK_W'($urandom_range(4, 1));
        end else if (r < 80) begin
            return TICK_W'($urandom_range(12, 5));
        end else if (r < 95) begin
            return TICK_W'($urandom);
        end
        return {TICK_W{1'b1}} - TICK_W'($urandom_range(1));
    endfunction

    function automatic t_cmd noise_cmd();
        return make_cmd(KIND_W'($urandom_range(7)), TICK_W'($urandom), TICK_W'($urandom),
                        TICK_W'($urandom));
    endfunction

    task automatic send_item(t_cmd c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        issued++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial begin
        int unsigned first_random;
        int          segment;
        int          cur_segment;
        int unsigned r;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rst_n        = 1'b0;
        cur_segment  = -1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run without idling.
        send_item(make_cmd(KIND_TICK, '0, '0, '0));
        send_item(make_cmd(KIND_START, '0, 16'd3, 16'd3));      // zero on time: ignored
        send_item(make_cmd(KIND_START, 16'd2, 16'd1, 16'd2));
        repeat (6) send_item(make_cmd(KIND_TICK, '1, '1, '1));  // runs the pattern to its end
        send_item(make_cmd(KIND_STOP, '0, '0, '0));
        send_item(make_cmd(KIND_START, '1, '1, '1));
        send_item(make_cmd(KIND_STOP, '0, '0, '0));             // buzzer holds its level
        send_item(make_cmd(KIND_TICK, '0, '0, '0));
        send_item(make_cmd(KIND_START, 16'd3, '0, '0));         // continuous tone
        send_item(make_cmd(KIND_TICK, '0, '0, '0));
        send_item(make_cmd(KIND_PAUSE, '0, '0, '0));
        send_item(make_cmd(KIND_START, 16'd1, 16'd1, 16'd1));   // muted: ignored
        send_item(make_cmd(KIND_KEY, '0, '0, '0));
        send_item(make_cmd(KIND_TICK, '0, '0, '0));
        send_item(make_cmd(KIND_RESUME, '0, '0, '0));
        send_item(make_cmd(KIND_KEY, '1, '1, '1));
        send_item(make_cmd(KIND_W'(6), '1, '1, '1));
        send_item(make_cmd(KIND_W'(7), '1, '1, '1));
        send_item(make_cmd(KIND_STOP, '0, '0, '0));
        send_item(make_cmd(KIND_TICK, '0, '0, '0));
        drain();

        first_random = issued;
        while (issued < first_random + RANDOM_ITEMS) begin
            segment = (issued - first_random) / SEGMENT_ITEMS;
            if (segment != cur_segment) begin
                drain();
                cur_segment = segment;
                case (segment % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                    default: begin send_idle_pct = 12; recv_stall_pct = 12; end
                endcase
            end
            r = $urandom_range(99);
            if (r < 60) begin
                // A pattern started and then ticked through, sometimes stopped.
                if ($urandom_range(4) == 0) begin
                    send_item(make_cmd(KIND_KEY, TICK_W'($urandom), TICK_W'($urandom),
                                       TICK_W'($urandom)));
                end else begin
                    send_item(make_cmd(KIND_START, pick_len(10), pick_len(15), pick_len(30)));
                end
                repeat ($urandom_range(40, 2)) begin
                    if ($urandom_range(19) == 0) begin
                        send_item(noise_cmd());
                    end else begin
                        send_item(make_cmd(KIND_TICK, TICK_W'($urandom), TICK_W'($urandom),
                                           TICK_W'($urandom)));
                    end
                end
                if ($urandom_range(1) == 1) begin
                    send_item(make_cmd(KIND_STOP, TICK_W'($urandom), '0, '0));
                end
            end else if (r < 75) begin
                send_item(make_cmd(KIND_PAUSE, '0, '0, '0));
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(2))
                        0: send_item(make_cmd(KIND_TICK, '0, '0, '0));
                        1: send_item(make_cmd(KIND_START, pick_len(0), pick_len(0),
                                              pick_len(0)));
                        default: send_item(make_cmd(KIND_KEY, '0, '0, '0));
                    endcase
                end
                send_item(make_cmd(KIND_RESUME, '0, '0, '0));
            end else begin
                repeat ($urandom_range(6, 1)) send_item(noise_cmd());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
